@@ rtl/wnq_pkg.sv @@
`default_nettype none
package wnq_pkg;
    localparam int MAX_GRID_WIDTH_DEF = 64;
    localparam int LEVEL_DEPTH = 16384;
    localparam int LEVEL_AW = 14;
    localparam int STEP_UP_Q8 = 154;
    localparam int STAND_HIGH_Q8 = 384;

    typedef enum logic [1:0] {
        OP_LOAD_COLUMN = 2'd0,
        OP_LOAD_LEVEL  = 2'd1,
        OP_QUERY       = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    localparam logic [0:0] CFG_GRID_WIDTH = 1'b0;
    localparam logic [0:0] CFG_GRID_DEPTH = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [13:0] table_index;
        logic [14:0] level_start;
        logic signed [23:0] floor_height;
        logic [22:0] headroom;
        logic signed [7:0] cell_x;
        logic signed [7:0] cell_z;
        logic signed [23:0] query_height;
    } item_t;

    typedef struct packed {
        logic air_here;
        logic wall_adjacent;
    } result_t;
endpackage
`default_nettype wire

@@ rtl/wnq_if.sv @@
`default_nettype none
interface wnq_in_if;
    logic valid;
    logic ready;
    wnq_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/wnq_out_if.sv @@
`default_nettype none
interface wnq_out_if;
    logic valid;
    logic ready;
    wnq_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/wnq_ram.sv @@
`default_nettype none
module wnq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/wnq_front.sv @@
`default_nettype none
// accepts items into a small queue; the back end pops them
module wnq_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    wnq_in_if.sink             in_ch,
    input  wire logic          pop,
    output logic               head_valid,
    output wnq_pkg::item_t     head
);
    localparam int QD = 2;
    wnq_pkg::item_t q_reg [QD];
    logic           rd_reg, rd_next;
    logic           wr_reg, wr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;

    assign in_ch.ready = (cnt_reg != 2'(QD));
    // unused operation codes never enter the queue
    assign push = in_ch.valid && in_ch.ready
                  && (in_ch.data.operation != wnq_pkg::OP_NONE);
    assign head_valid = (cnt_reg != 2'd0);
    assign head = q_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= in_ch.data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QD)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid) else $error("pop from empty queue");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QD)) |-> !in_ch.ready) else $error("ready while full");
endmodule
`default_nettype wire

@@ rtl/wnq_back.sv @@
`default_nettype none
module wnq_back #(
    parameter int MAX_GRID_WIDTH = wnq_pkg::MAX_GRID_WIDTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic [6:0] grid_width,
    input  wire logic [6:0] grid_depth,
    input  wire logic      head_valid,
    input  wire wnq_pkg::item_t head,
    output logic           pop,
    wnq_out_if.source      out_ch
);
    localparam int CDEPTH = MAX_GRID_WIDTH * MAX_GRID_WIDTH + 1;
    localparam int CAW = $clog2(CDEPTH);
    localparam int DW = $clog2(MAX_GRID_WIDTH + 1);
    localparam int GW = (DW > 7) ? DW : 7;

    typedef enum logic [2:0] {
        S_IDLE, S_COL_LO, S_COL_HI, S_LVL_ADDR, S_LVL_WAIT, S_LVL_CHECK, S_NEXT, S_OUT
    } state_t;

    state_t state_reg;
    logic [3:0] nb_reg;
    logic [1:0] dx_reg, dz_reg;
    logic [15:0] lvl_reg, hi_reg;
    logic room_reg, air_reg, wall_reg;
    logic [CAW-1:0] col_reg;
    logic out_valid_reg;
    wnq_pkg::result_t out_reg;

    // column table
    logic col_we;
    logic [CAW-1:0] col_raddr;
    logic [14:0] col_rdata;
    // level tables
    logic lvl_we;
    logic [23:0] floor_rdata;
    logic [22:0] room_rdata;

    // used dimensions, clamped to the maximum
    logic [GW-1:0] w_used, d_used;
    assign w_used = (GW'(grid_width) > GW'(MAX_GRID_WIDTH)) ? GW'(MAX_GRID_WIDTH)
                                                            : GW'(grid_width);
    assign d_used = (GW'(grid_depth) > GW'(MAX_GRID_WIDTH)) ? GW'(MAX_GRID_WIDTH)
                                                            : GW'(grid_depth);

    // neighbour offsets from dx_reg/dz_reg: 0..2 with 1 the centre
    logic signed [9:0] nx, nz;
    logic on_grid;
    logic [CAW-1:0] col_idx;
    always_comb
    begin
        nx = 10'(head.cell_x) + signed'(10'(dx_reg)) - 10'sd1;
        nz = 10'(head.cell_z) + signed'(10'(dz_reg)) - 10'sd1;
        on_grid = !nx[9] && !nz[9] && (10'(w_used) > nx) && (10'(d_used) > nz);
        col_idx = CAW'(32'(nz[8:0]) * 32'(w_used) + 32'(nx[8:0]));
    end

    assign col_we = head_valid && (state_reg == S_IDLE)
                    && (head.operation == wnq_pkg::OP_LOAD_COLUMN)
                    && (32'(head.table_index) < 32'(CDEPTH));
    assign lvl_we = head_valid && (state_reg == S_IDLE)
                    && (head.operation == wnq_pkg::OP_LOAD_LEVEL);
    assign col_raddr = (state_reg == S_COL_LO) ? col_reg : CAW'(col_reg + 1'b1);

    wnq_ram #(.WIDTH(15), .DEPTH(CDEPTH)) u_col (
        .clk(clk), .we(col_we), .waddr(CAW'(head.table_index)),
        .wdata(head.level_start), .raddr(col_raddr), .rdata(col_rdata));
    wnq_ram #(.WIDTH(24), .DEPTH(wnq_pkg::LEVEL_DEPTH)) u_floor (
        .clk(clk), .we(lvl_we), .waddr(head.table_index),
        .wdata(head.floor_height), .raddr(lvl_reg[13:0]), .rdata(floor_rdata));
    wnq_ram #(.WIDTH(23), .DEPTH(wnq_pkg::LEVEL_DEPTH)) u_room (
        .clk(clk), .we(lvl_we), .waddr(head.table_index),
        .wdata(head.headroom), .raddr(lvl_reg[13:0]), .rdata(room_rdata));

    // standing-room test for the level just read
    logic signed [26:0] y_lo, y_hi, top;
    logic fits;
    always_comb
    begin
        y_lo = 27'(head.query_height) + 27'(wnq_pkg::STEP_UP_Q8);
        y_hi = 27'(head.query_height) + 27'(wnq_pkg::STAND_HIGH_Q8);
        top  = 27'(signed'(floor_rdata)) + 27'({1'b0, room_rdata});
        fits = (27'(signed'(floor_rdata)) <= y_lo) && (top >= y_hi);
    end

    assign pop = head_valid && (((state_reg == S_IDLE)
                 && (head.operation != wnq_pkg::OP_QUERY))
                 || ((state_reg == S_OUT) && !out_valid_reg));
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            nb_reg   <= 4'd0;
            dx_reg   <= 2'd0;
            dz_reg   <= 2'd0;
            room_reg <= 1'b0;
            air_reg  <= 1'b0;
            wall_reg <= 1'b0;
            col_reg  <= '0;
            lvl_reg  <= 16'd0;
            hi_reg   <= 16'd0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (head_valid && head.operation == wnq_pkg::OP_QUERY)
                    begin
                        nb_reg   <= 4'd0;
                        dx_reg   <= 2'd0;
                        dz_reg   <= 2'd0;
                        wall_reg <= 1'b0;
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    room_reg <= 1'b0;
                    col_reg  <= col_idx;
                    state_reg <= on_grid ? S_COL_LO : S_LVL_CHECK;
                end
                S_COL_LO: state_reg <= S_COL_HI;
                S_COL_HI:
                begin
                    lvl_reg <= 16'(col_rdata);
                    state_reg <= S_LVL_ADDR;
                end
                S_LVL_ADDR:
                begin
                    hi_reg <= (col_rdata > 15'(wnq_pkg::LEVEL_DEPTH))
                              ? 16'(wnq_pkg::LEVEL_DEPTH) : 16'(col_rdata);
                    state_reg <= S_LVL_WAIT;
                end
                S_LVL_WAIT:
                begin
                    if (lvl_reg >= hi_reg)
                    begin
                        state_reg <= S_LVL_CHECK;
                    end
                    else
                    begin
                        state_reg <= S_LVL_CHECK;
                        room_reg <= 1'b0;
                    end
                end
                S_LVL_CHECK:
                begin
                    if ((lvl_reg < hi_reg) && on_grid && !room_reg)
                    begin
                        if (fits)
                        begin
                            room_reg <= 1'b1;
                            state_reg <= S_LVL_CHECK;
                        end
                        else
                        begin
                            lvl_reg <= lvl_reg + 16'd1;
                            state_reg <= S_LVL_WAIT;
                        end
                    end
                    else
                    begin
                        if (nb_reg == 4'd4)
                        begin
                            air_reg <= room_reg;
                        end
                        else if (!room_reg)
                        begin
                            wall_reg <= 1'b1;
                        end
                        if (nb_reg == 4'd8)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            nb_reg <= nb_reg + 4'd1;
                            if (dx_reg == 2'd2)
                            begin
                                dx_reg <= 2'd0;
                                dz_reg <= dz_reg + 2'd1;
                            end
                            else
                            begin
                                dx_reg <= dx_reg + 2'd1;
                            end
                            state_reg <= S_NEXT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && !out_valid_reg)
        begin
            out_reg.air_here      <= air_reg;
            out_reg.wall_adjacent <= wall_reg;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg) else $error("result dropped");
    a_nb_range: assert property (@(posedge clk) disable iff (!rst_n)
        nb_reg <= 4'd8) else $error("neighbour count out of range");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE || state_reg == S_OUT)) else $error("bad pop");
endmodule
`default_nettype wire

@@ rtl/walkable_neighbour_query_core.sv @@
`default_nettype none
// walkable neighbour query
// in_ch carries load and query items (valid/ready); out_ch carries one
// result item (air_here, wall_adjacent) per query, none for loads.
// a load passes through the queue and is written once it is at the queue
// head and no query is running, so loads stream at one per cycle while no
// query holds the back end. a query visits the nine columns in turn: for an
// on-grid column it reads the level list bounds from the column table, then
// tests the levels one at a time, as each table has a single read port,
// until one fits; an off-grid column counts as having no room. a two-entry
// queue sits in front, so items are taken while a query runs. the result
// register holds an item until out_ch.ready; while it waits the next query
// stops just before delivering.
// reset clears control state and sets grid_width and grid_depth to 64;
// table contents are undefined until loaded. configuration is to be written
// by the user through cfg_we/cfg_index/cfg_data while idle; not enforced.
module walkable_neighbour_query_core #(
    parameter int MAX_GRID_WIDTH = wnq_pkg::MAX_GRID_WIDTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [6:0] cfg_data,
    wnq_in_if.sink          in_ch,
    wnq_out_if.source       out_ch
);
    logic [6:0] grid_width_reg, grid_depth_reg;
    logic head_valid, pop;
    wnq_pkg::item_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= 7'd64;
            grid_depth_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wnq_pkg::CFG_GRID_WIDTH: grid_width_reg <= cfg_data;
                wnq_pkg::CFG_GRID_DEPTH: grid_depth_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    wnq_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .pop(pop),
        .head_valid(head_valid), .head(head));

    wnq_back #(.MAX_GRID_WIDTH(MAX_GRID_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .grid_width(grid_width_reg),
        .grid_depth(grid_depth_reg), .head_valid(head_valid), .head(head),
        .pop(pop), .out_ch(out_ch));
endmodule
`default_nettype wire
